>>> hdl/sorted_key_value_table_macros.svh
// ----------------------------------------------------------------------------
// sorted_key_value_table_macros.svh
// Assertion macros used by the checker of the sorted key/value table.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SKVT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SKVT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Types and constants of the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int CMD_W     = 2;
   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;
   localparam int STAT_W    = 2;
   localparam int OCC_W     = 5;

   // value returned when no data is found
   localparam logic signed [VAL_W-1:0] VALUE_NONE = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_INS,
      S_DEL_FIND,
      S_DEL_SHIFT,
      S_SRCH,
      S_FINISH
   } state_type;

endpackage

>>> hdl/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Table of up to DEPTH key/data pairs held in ascending signed key order.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command word (insert, delete, search) with key and data.
//   rsp_* returns exactly one word per command: status, search data and the
//   number of entries held after the command.
//   Both channels use valid/ready; a word moves when both are high.
// Timing:
//   One command at a time. Insert walks down from the top entry to its slot,
//   delete walks up to the match and then to the top, search walks up to the
//   first key not below. The single read port of the entry memory and the
//   shared key compare unit serve every step.
//   req_ready is high only while no command is in progress.
// Reset:
//   Synchronous, active high; the table is emptied at once (entry count only,
//   memory contents are left as they are). No clearing pass.
// Stall:
//   A finished result sits in the output register; the next command is taken
//   while it waits. A command that finishes before rsp_ready frees the
//   output register holds in its last step.
// ----------------------------------------------------------------------------
module sorted_key_value_table
   import skvt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic signed [KEY_W-1:0]  req_key,
   input  logic signed [VAL_W-1:0]  req_value_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [VAL_W-1:0]  rsp_value_out,
   output logic [OCC_W-1:0]         rsp_occupancy
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type               state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [CW-1:0]           pos_ff, pos_in;
   logic [CW-1:0]           count_ff, count_in;
   status_type              res_status_ff, res_status_in;
   logic signed [VAL_W-1:0] res_value_ff, res_value_in;

   // entry memory, one write and one registered read per cycle
   logic signed [KEY_W-1:0] key_mem_ff [DEPTH];
   logic signed [VAL_W-1:0] val_mem_ff [DEPTH];
   logic signed [KEY_W-1:0] rd_key_ff;
   logic signed [VAL_W-1:0] rd_val_ff;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic signed [KEY_W-1:0] wr_key;
   logic signed [VAL_W-1:0] wr_val;

   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic [OCC_W-1:0]        rsp_occ_ff;
   logic                    load_rsp;

   logic                    req_accept;
   logic                    key_lt, key_eq, is_full;
   logic [CW-1:0]           pos_m1, pos_m2, pos_p1, pos_p2, cnt_m1;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;

   // shared compare unit: stored key against command key
   assign key_lt  = (rd_key_ff < key_ff);
   assign key_eq  = (rd_key_ff == key_ff);
   assign is_full = (count_ff == CW'(DEPTH));

   assign pos_m1 = pos_ff - CW'(1);
   assign pos_m2 = pos_ff - CW'(2);
   assign pos_p1 = pos_ff + CW'(1);
   assign pos_p2 = pos_ff + CW'(2);
   assign cnt_m1 = count_ff - CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_START;
         end
         S_START: begin
            unique case (cmd_ff)
               CMD_INSERT: state_in = is_full ? S_FINISH : S_INS;
               CMD_DELETE: state_in = S_DEL_FIND;
               CMD_SEARCH: state_in = S_SRCH;
               default:    state_in = S_FINISH;
            endcase
         end
         S_INS: begin
            if (pos_ff == '0 || key_lt) state_in = S_FINISH;
         end
         S_DEL_FIND: begin
            if (pos_ff == count_ff) state_in = S_FINISH;
            else if (key_eq)        state_in = S_DEL_SHIFT;
         end
         S_DEL_SHIFT: begin
            if (pos_p1 == count_ff) state_in = S_FINISH;
         end
         S_SRCH: begin
            if (pos_ff == count_ff || !key_lt) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control per step
   always_comb begin
      pos_in        = pos_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rd_addr       = pos_p1[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = pos_ff[AW-1:0];
      wr_key        = rd_key_ff;
      wr_val        = rd_val_ff;
      load_rsp      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
         end
         S_START: begin
            res_status_in = ST_MISS;
            res_value_in  = VALUE_NONE;
            pos_in        = '0;
            rd_addr       = '0;
            if (cmd_ff == CMD_INSERT) begin
               // walk down from the top entry
               pos_in  = count_ff;
               rd_addr = cnt_m1[AW-1:0];
               if (is_full) res_status_in = ST_FULL;
            end
         end
         S_INS: begin
            // bus holds entry pos-1; either place the new pair or move it up
            wr_en = 1'b1;
            if (pos_ff == '0 || key_lt) begin
               wr_key        = key_ff;
               wr_val        = val_ff;
               count_in      = count_ff + CW'(1);
               res_status_in = ST_OK;
            end else begin
               rd_addr = pos_m2[AW-1:0];
               pos_in  = pos_m1;
            end
         end
         S_DEL_FIND: begin
            // bus holds entry pos; read of pos+1 serves both outcomes
            if (pos_ff != count_ff && !key_eq) pos_in = pos_p1;
         end
         S_DEL_SHIFT: begin
            // bus holds entry pos+1, moved down into pos
            if (pos_p1 == count_ff) begin
               count_in      = cnt_m1;
               res_status_in = ST_OK;
            end else begin
               wr_en   = 1'b1;
               pos_in  = pos_p1;
               rd_addr = pos_p2[AW-1:0];
            end
         end
         S_SRCH: begin
            if (pos_ff != count_ff) begin
               if (!key_lt) begin
                  if (key_eq) begin
                     res_status_in = ST_OK;
                     res_value_in  = rd_val_ff;
                  end
               end else begin
                  pos_in = pos_p1;
               end
            end
         end
         S_FINISH: begin
            load_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load_rsp)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // command and work registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
         val_ff <= req_value_in;
      end
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
   end

   // result word
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_occ_ff    <= OCC_W'(count_ff);
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_key;
         val_mem_ff[wr_addr] <= wr_val;
      end
      rd_key_ff <= key_mem_ff[rd_addr];
      rd_val_ff <= val_mem_ff[rd_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

>>> hdl/skvt_checker.sv
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level checks of the sorted key/value table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_key_value_table_macros.svh"

module skvt_checker
   import skvt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [CMD_W-1:0]         req_command,
   input logic signed [KEY_W-1:0]  req_key,
   input logic signed [VAL_W-1:0]  req_value_in,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STAT_W-1:0]        rsp_status,
   input logic signed [VAL_W-1:0]  rsp_value_out,
   input logic [OCC_W-1:0]         rsp_occupancy
);

   // a stalled result word holds
   `SKVT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_value_out) && $stable(rsp_occupancy), "result word changed while stalled")

   // one command at a time: busy right after a word is taken
   `SKVT_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "command taken while previous one in progress")

   // a miss or full status returns no data
   `SKVT_ASSERT_IMP(a_miss_value, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_value_out == VALUE_NONE, "data returned with miss or full status")

   // a dropped insert reports a full table
   `SKVT_ASSERT_IMP(a_full_occ, clock, reset, rsp_valid && rsp_status == ST_FULL, rsp_occupancy == OCC_W'(DEPTH), "full status with table not full")

endmodule

bind sorted_key_value_table skvt_checker #(.DEPTH(DEPTH)) u_skvt_checker (.*);

>>> tb/sorted_key_value_table_test.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_test
// Self-checking bench for the sorted key/value table. A table model inside
// the bench predicts the response word of every command. Each response
// returned is compared field by field with the oldest prediction. Stimulus
// is a directed corner pass (empty, full, duplicate keys, extreme keys,
// unused command code) followed by random traffic over a small key pool.
// The random traffic runs under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module sorted_key_value_table_test;
   import skvt_pkg::*;

   localparam int                 TABLE_DEPTH  = DEPTH_DEF;
   localparam logic [CMD_W-1:0]   CMD_UNUSED   = 2'd3;
   localparam int                 KEY_POOL_LEN = 8;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   typedef struct packed {
      status_type                status;
      logic signed [VAL_W-1:0]   value;
      logic [OCC_W-1:0]          occupancy;
   } table_reply_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_command;
   logic signed [KEY_W-1:0]  req_key;
   logic signed [VAL_W-1:0]  req_value_in;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [VAL_W-1:0]  rsp_value_out;
   logic [OCC_W-1:0]         rsp_occupancy;

   // table model and replies still owed by the block
   logic signed [KEY_W-1:0]  model_keys [TABLE_DEPTH];
   logic signed [VAL_W-1:0]  model_values [TABLE_DEPTH];
   int                       model_count;
   table_reply_type          pending_replies [$];
   logic signed [KEY_W-1:0]  key_pool [KEY_POOL_LEN];

   int unsigned              sender_idle_pct;
   int unsigned              receiver_stall_pct;
   int                       error_count;

   sorted_key_value_table i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_key       (req_key),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_occupancy (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // apply one command to the model, return the reply it owes
   function automatic table_reply_type apply_table_command(input logic [CMD_W-1:0] cmd,
         input logic signed [KEY_W-1:0] k, input logic signed [VAL_W-1:0] v);
      table_reply_type reply;
      int pos;
      reply.status = ST_MISS;
      reply.value  = VALUE_NONE;
      pos = 0;
      if (cmd == CMD_INSERT) begin
         if (model_count >= TABLE_DEPTH) begin
            reply.status = ST_FULL;
         end else begin
            while (pos < model_count && model_keys[pos] < k) pos++;
            for (int j = model_count; j > pos; j--) begin
               model_keys[j]   = model_keys[j-1];
               model_values[j] = model_values[j-1];
            end
            model_keys[pos]   = k;
            model_values[pos] = v;
            model_count++;
            reply.status = ST_OK;
         end
      end else if (cmd == CMD_DELETE) begin
         while (pos < model_count && model_keys[pos] != k) pos++;
         if (pos < model_count) begin
            for (int j = pos; j + 1 < model_count; j++) begin
               model_keys[j]   = model_keys[j+1];
               model_values[j] = model_values[j+1];
            end
            model_count--;
            reply.status = ST_OK;
         end
      end else if (cmd == CMD_SEARCH) begin
         while (pos < model_count && model_keys[pos] < k) pos++;
         if (pos < model_count && model_keys[pos] == k) begin
            reply.status = ST_OK;
            reply.value  = model_values[pos];
         end
      end
      reply.occupancy = model_count[OCC_W-1:0];
      return reply;
   endfunction

   // drive one command word, wait for it to be taken, record the prediction
   task automatic send_command(input logic [CMD_W-1:0] cmd,
         input logic signed [KEY_W-1:0] k, input logic signed [VAL_W-1:0] v);
      @(negedge clock);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_key      <= k;
      req_value_in <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_replies.push_back(apply_table_command(cmd, k, v));
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      table_reply_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status    = status_type'(rsp_status);
         got.value     = rsp_value_out;
         got.occupancy = rsp_occupancy;
         if (pending_replies.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response word: status %0d value %0d occupancy %0d",
                        got.status, got.value, got.occupancy);
         end else begin
            want = pending_replies.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10)
                  $display("response %s: status %0d/%0d value %0d/%0d occupancy %0d/%0d",
                           "exp/got", want.status, got.status, want.value, got.value,
                           want.occupancy, got.occupancy);
            end
         end
      end
   end

   function automatic logic signed [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, KEY_POOL_LEN-1)];
      return $urandom;
   endfunction

   // pool of keys reused so deletes and searches mostly hit
   task automatic refresh_key_pool();
      key_pool[0] = KEY_MAX;
      key_pool[1] = KEY_MIN;
      key_pool[2] = $urandom_range(0, 3);
      key_pool[3] = -$signed($urandom_range(1, 3));
      for (int i = 4; i < KEY_POOL_LEN; i++) key_pool[i] = $urandom;
   endtask

   // random command mix; insert weight swings so the table fills and drains
   task automatic run_random_traffic(input int count, input int unsigned send_pct,
         input int unsigned recv_pct);
      int pick;
      int ins_pct;
      logic [CMD_W-1:0] cmd;
      logic signed [VAL_W-1:0] data;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = recv_pct;
      refresh_key_pool();
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 50) refresh_key_pool();
         ins_pct = ((n / 40) % 2 == 0) ? 60 : 25;
         pick = $urandom_range(0, 99);
         if (pick < 4)
            cmd = CMD_UNUSED;
         else if (pick < 4 + ins_pct)
            cmd = CMD_INSERT;
         else if (pick < 4 + ins_pct + (96 - ins_pct) / 2)
            cmd = CMD_DELETE;
         else
            cmd = CMD_SEARCH;
         data = ($urandom_range(0, 19) == 0) ? VALUE_NONE : $signed($urandom);
         send_command(cmd, pick_key(), data);
      end
   endtask

   // empty and full table, duplicates, extreme keys, data of -1, unused code
   task automatic test_directed_corners();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_command(CMD_SEARCH, 0, 0);
      send_command(CMD_DELETE, 0, 0);
      send_command(CMD_UNUSED, KEY_MAX, KEY_MIN);
      send_command(CMD_INSERT, KEY_MAX, 32'sd1);
      send_command(CMD_INSERT, KEY_MIN, KEY_MAX);
      send_command(CMD_INSERT, 0, VALUE_NONE);
      send_command(CMD_INSERT, 0, 32'sh1234_5678);
      send_command(CMD_SEARCH, 0, 0);
      send_command(CMD_DELETE, 0, 0);
      send_command(CMD_SEARCH, 0, 0);
      for (int i = 0; i < TABLE_DEPTH - 3; i++)
         send_command(CMD_INSERT, $urandom, $urandom);
      send_command(CMD_INSERT, 32'sd7, 32'sd7);
      send_command(CMD_SEARCH, KEY_MAX, 0);
      send_command(CMD_DELETE, KEY_MAX, 0);
      send_command(CMD_DELETE, KEY_MIN, 0);
   endtask

   task automatic test_random_no_idle();
      run_random_traffic(300, 0, 0);
   endtask

   task automatic test_random_sender_idle();
      run_random_traffic(300, 57, 0);
   endtask

   task automatic test_random_receiver_stall();
      run_random_traffic(300, 0, 57);
   endtask

   task automatic test_random_both_idle();
      run_random_traffic(300, 11, 11);
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = CMD_INSERT;
      req_key            = '0;
      req_value_in       = '0;
      rsp_ready          = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      error_count        = 0;
      model_count        = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_replies.size() == 0) begin
         $display("sorted_key_value_table: match");
      end else begin
         $display("sorted_key_value_table: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("sorted_key_value_table: mismatch");
      $finish;
   end

endmodule

>>> sorted_key_value_table.f
+incdir+hdl
hdl/skvt_pkg.sv
hdl/sorted_key_value_table.sv
hdl/skvt_checker.sv
tb/sorted_key_value_table_test.sv
